### hw/rtl/mffd_pkg.sv
// Shared types, constants and register indexes of the motor feedback frame decoder.
package mffd_pkg;

  localparam int MOTORS_PER_BUS_DEF = 8;

  localparam int ID_W     = 11;
  localparam int CALIB_W  = 8;
  localparam int ANGLE_W  = 16;
  localparam int TURNS_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ID      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CALIB_FRAMES = 2'd1;

  localparam logic [ID_W-1:0]    BASE_ID_RESET      = 11'd513;
  localparam logic [CALIB_W-1:0] CALIB_FRAMES_RESET = 8'd50;

  localparam logic signed [ANGLE_W:0] HALF_TURN = 17'sd4096;
  localparam int TURN_SHIFT = 13;
  localparam logic [CALIB_W-1:0] COUNT_MAX = 8'd255;

  typedef struct packed {
    logic [ID_W-1:0]    base_id;
    logic [CALIB_W-1:0] calib_frames;
  } cfg_t;

  typedef struct packed {
    logic            bus;
    logic [ID_W-1:0] frame_id;
    logic [7:0]      byte0;
    logic [7:0]      byte1;
    logic [7:0]      byte2;
    logic [7:0]      byte3;
    logic [7:0]      byte4;
    logic [7:0]      byte5;
    logic [7:0]      byte6;
  } frame_t;

  typedef struct packed {
    logic [CALIB_W-1:0] frame_count;
    logic [ANGLE_W-1:0] current_angle;
    logic [ANGLE_W-1:0] zero_angle;
    logic [TURNS_W-1:0] turn_count;
  } entry_t;

  typedef struct packed {
    logic                      bus;
    logic [2:0]                motor_index;
    logic                      calibrating;
    logic [ANGLE_W-1:0]        rotor_angle;
    logic signed [15:0]        rotor_speed;
    logic signed [15:0]        torque_current;
    logic [7:0]                temperature;
    logic signed [TURNS_W-1:0] turns;
    logic signed [TURNS_W-1:0] unwrapped_angle;
  } result_t;

endpackage

### hw/rtl/mffd_cfg_regs.sv
// Configuration registers: base identifier and capture frame count.
module mffd_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mffd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mffd_pkg::CFG_DATA_W-1:0]   cfg_data,
  output mffd_pkg::cfg_t                    cfg
);

  mffd_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_id      <= mffd_pkg::BASE_ID_RESET;
      cfg_r.calib_frames <= mffd_pkg::CALIB_FRAMES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mffd_pkg::REG_BASE_ID:      cfg_r.base_id      <= cfg_data[mffd_pkg::ID_W-1:0];
        mffd_pkg::REG_CALIB_FRAMES: cfg_r.calib_frames <= cfg_data[mffd_pkg::CALIB_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/mffd_store.sv
// Per-motor state store with one combinational read port and one write port.
module mffd_store #(
  parameter int MOTORS_PER_BUS = mffd_pkg::MOTORS_PER_BUS_DEF,
  localparam int ENTRIES = 2 * MOTORS_PER_BUS,
  localparam int EW = $clog2(ENTRIES)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [EW-1:0]    rd_addr,
  output mffd_pkg::entry_t rd_entry,
  input  logic             wr_en,
  input  logic [EW-1:0]    wr_addr,
  input  mffd_pkg::entry_t wr_entry
);

  mffd_pkg::entry_t mem_r [ENTRIES];

  assign rd_entry = mem_r[rd_addr];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ENTRIES; k++) begin
        mem_r[k] <= '0;
      end
    end else if (wr_en) begin
      mem_r[wr_addr] <= wr_entry;
    end
  end

endmodule

### hw/rtl/mffd_update.sv
// Frame decode, offset capture and turn unwrap for one selected motor entry.
module mffd_update #(
  parameter int MOTORS_PER_BUS = mffd_pkg::MOTORS_PER_BUS_DEF,
  localparam int EW = $clog2(2 * MOTORS_PER_BUS)
) (
  input  mffd_pkg::cfg_t    cfg,
  input  mffd_pkg::frame_t  frame,
  output logic              hit,
  output logic [EW-1:0]     entry_addr,
  input  mffd_pkg::entry_t  entry,
  output mffd_pkg::entry_t  entry_nxt,
  output mffd_pkg::result_t result
);

  localparam logic [mffd_pkg::ID_W-1:0] MotorsW = mffd_pkg::ID_W'(MOTORS_PER_BUS);

  logic [mffd_pkg::ID_W:0]              id_diff;
  logic [mffd_pkg::ID_W-1:0]            idx;
  logic [mffd_pkg::ID_W:0]              entry_full;
  logic [mffd_pkg::ANGLE_W-1:0]         ang;
  logic                                 calib;
  logic signed [mffd_pkg::ANGLE_W:0]    diff;
  logic [mffd_pkg::TURNS_W-1:0]         turns_nxt;
  logic [mffd_pkg::TURNS_W-1:0]         total;

  always_comb begin
    id_diff    = {1'b0, frame.frame_id} - {1'b0, cfg.base_id};
    idx        = id_diff[mffd_pkg::ID_W-1:0];
    // Identifiers below the base show up as a borrow out of the subtraction.
    hit        = !id_diff[mffd_pkg::ID_W] && (idx < MotorsW);
    entry_full = {1'b0, idx} + (frame.bus ? {1'b0, MotorsW} : '0);
    entry_addr = entry_full[EW-1:0];

    ang   = {frame.byte0, frame.byte1};
    calib = entry.frame_count <= cfg.calib_frames;
    diff  = $signed({1'b0, ang}) - $signed({1'b0, entry.current_angle});

    turns_nxt = entry.turn_count;
    if (!calib) begin
      if (diff > mffd_pkg::HALF_TURN) begin
        turns_nxt = entry.turn_count - 32'd1;
      end else if (diff < -mffd_pkg::HALF_TURN) begin
        turns_nxt = entry.turn_count + 32'd1;
      end
    end

    entry_nxt               = entry;
    entry_nxt.current_angle = ang;
    entry_nxt.turn_count    = turns_nxt;
    if (calib) begin
      entry_nxt.zero_angle = ang;
      if (entry.frame_count != mffd_pkg::COUNT_MAX) begin
        entry_nxt.frame_count = entry.frame_count + 8'd1;
      end
    end

    total = {turns_nxt[mffd_pkg::TURNS_W-mffd_pkg::TURN_SHIFT-1:0],
             {mffd_pkg::TURN_SHIFT{1'b0}}}
            + {16'd0, ang} - {16'd0, entry_nxt.zero_angle};

    result.bus             = frame.bus;
    result.motor_index     = idx[2:0];
    result.calibrating     = calib;
    result.rotor_angle     = ang;
    result.rotor_speed     = calib ? 16'sd0 : $signed({frame.byte2, frame.byte3});
    result.torque_current  = calib ? 16'sd0 : $signed({frame.byte4, frame.byte5});
    result.temperature     = calib ? 8'd0 : frame.byte6;
    result.turns           = $signed(turns_nxt);
    result.unwrapped_angle = $signed(total);
  end

endmodule

### hw/rtl/motor_feedback_frame_decoder.sv
// Top level of the motor feedback frame decoder with multi-turn angle unwrap.
//
// Usage: each request on the in_ channel is one received feedback frame (bus,
// standard identifier, seven payload bytes). A frame whose identifier falls in
// base_identifier .. base_identifier + MOTORS_PER_BUS - 1 updates the state of
// that motor on its bus and gives one request on the out_ channel; any other
// frame is dropped without a result. The cfg_ channel writes the base
// identifier (index 0) and the capture frame count (index 1); cfg_ready is
// always high and unknown indexes are ignored.
// A frame is held in the input register, passes through the state update and
// has its result registered in the output register. Throughput is one frame
// per cycle unless the receiver stalls, set by the single read-modify-write of
// the motor state store between the input and output registers.
// Reset clears all motor entries at once and loads the register defaults.
// When the receiver stalls, the result holds in the output register; the
// input register still takes one more frame, then in_stall rises.
module motor_feedback_frame_decoder #(
  parameter int MOTORS_PER_BUS = mffd_pkg::MOTORS_PER_BUS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_bus,
  input  logic [mffd_pkg::ID_W-1:0]             in_frame_id,
  input  logic [7:0]                            in_byte0,
  input  logic [7:0]                            in_byte1,
  input  logic [7:0]                            in_byte2,
  input  logic [7:0]                            in_byte3,
  input  logic [7:0]                            in_byte4,
  input  logic [7:0]                            in_byte5,
  input  logic [7:0]                            in_byte6,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_bus,
  output logic [2:0]                            out_motor_index,
  output logic                                  out_calibrating,
  output logic [mffd_pkg::ANGLE_W-1:0]          out_rotor_angle,
  output logic signed [15:0]                    out_rotor_speed,
  output logic signed [15:0]                    out_torque_current,
  output logic [7:0]                            out_temperature,
  output logic signed [mffd_pkg::TURNS_W-1:0]   out_turns,
  output logic signed [mffd_pkg::TURNS_W-1:0]   out_unwrapped_angle,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mffd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mffd_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int EW = $clog2(2 * MOTORS_PER_BUS);

  mffd_pkg::cfg_t    cfg;
  mffd_pkg::frame_t  frame_r;
  logic              frame_valid_r;
  mffd_pkg::result_t res_r;
  mffd_pkg::result_t res_nxt;
  logic              res_valid_r;
  logic              hit;
  logic              frame_fire;
  logic              out_free;
  logic [EW-1:0]     entry_addr;
  mffd_pkg::entry_t  entry;
  mffd_pkg::entry_t  entry_nxt;

  mffd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mffd_update #(.MOTORS_PER_BUS(MOTORS_PER_BUS)) u_update (
    .cfg        (cfg),
    .frame      (frame_r),
    .hit        (hit),
    .entry_addr (entry_addr),
    .entry      (entry),
    .entry_nxt  (entry_nxt),
    .result     (res_nxt)
  );

  mffd_store #(.MOTORS_PER_BUS(MOTORS_PER_BUS)) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (entry_addr),
    .rd_entry (entry),
    .wr_en    (frame_fire && hit),
    .wr_addr  (entry_addr),
    .wr_entry (entry_nxt)
  );

  // The frame in the input register is processed once the output register can take it.
  assign out_free   = !res_valid_r || !out_stall;
  assign frame_fire = frame_valid_r && out_free;
  assign in_stall   = frame_valid_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_valid_r <= 1'b0;
    end else if (!in_stall) begin
      frame_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      frame_r.bus      <= in_bus;
      frame_r.frame_id <= in_frame_id;
      frame_r.byte0    <= in_byte0;
      frame_r.byte1    <= in_byte1;
      frame_r.byte2    <= in_byte2;
      frame_r.byte3    <= in_byte3;
      frame_r.byte4    <= in_byte4;
      frame_r.byte5    <= in_byte5;
      frame_r.byte6    <= in_byte6;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (out_free) begin
      res_valid_r <= frame_fire && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_fire && hit) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = res_valid_r;
  assign out_bus             = res_r.bus;
  assign out_motor_index     = res_r.motor_index;
  assign out_calibrating     = res_r.calibrating;
  assign out_rotor_angle     = res_r.rotor_angle;
  assign out_rotor_speed     = res_r.rotor_speed;
  assign out_torque_current  = res_r.torque_current;
  assign out_temperature     = res_r.temperature;
  assign out_turns           = res_r.turns;
  assign out_unwrapped_angle = res_r.unwrapped_angle;

  a_stall_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> frame_valid_r && res_valid_r && out_stall)
    else $error("input stalled without a blocked frame");

  a_hit_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    frame_fire && hit |=> res_valid_r)
    else $error("matching frame produced no result");

  a_calib_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && res_r.calibrating |->
      res_r.rotor_speed == 16'sd0 && res_r.torque_current == 16'sd0 &&
      res_r.temperature == 8'd0)
    else $error("decoded fields not cleared during offset capture");

  a_calib_total: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && res_r.calibrating |->
      res_r.unwrapped_angle == (res_r.turns <<< mffd_pkg::TURN_SHIFT))
    else $error("total angle during capture is not whole turns");

  a_miss_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    frame_fire && !hit && !res_valid_r |=> !res_valid_r)
    else $error("out-of-window frame produced a result");

endmodule
